// ----- rtl/ebc_pkg.sv -----
// Shared constants, types and tables for the exponential brightness curve.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package ebc_pkg;

  localparam int FB = 16;                 // fraction bits of x and of the curve
  localparam int PFB = 12;                // fraction bits of the power register
  localparam int LW = 16;                 // level width
  localparam int XW = FB + 1;             // x in [0, 1] needs one integer bit
  localparam int QW = XW;                 // quotient bits produced by a divider
  localparam int DIV_NW = 48;             // divider dividend width
  localparam int DIV_DW = 32;             // divider divisor / remainder width
  localparam int HTERMS = 12;             // Horner terms of the exp series
  localparam int EXP_LAT = 3 + 3 * HTERMS + 1;
  localparam int LIN_LIMIT = 1 << PFB;    // 100*|p| below this selects linear

  localparam logic [XW-1:0] ONE_X = XW'(1) << FB;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [28:0] LOG2E_Q28 = 29'h1715_4765;
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  localparam logic [1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [1:0] REG_CURVE_MIN = 2'd1;
  localparam logic [1:0] REG_CURVE_MAX = 2'd2;
  localparam logic [1:0] REG_CURVE_POWER = 2'd3;

  typedef struct packed {
    logic sat;              // level was clamped
    logic byp;              // curve bypasses the quotient
    logic [XW-1:0] x;       // fraction carried along the pipe
  } side_t;

  // floor(2^32 / k); k = 1 uses all ones, corrected by one step later
  function automatic logic [31:0] recip_q32(input int k);
    logic [31:0] m;
    case (k)
      2: m = 32'h8000_0000;
      3: m = 32'h5555_5555;
      4: m = 32'h4000_0000;
      5: m = 32'h3333_3333;
      6: m = 32'h2AAA_AAAA;
      7: m = 32'h2492_4924;
      8: m = 32'h2000_0000;
      9: m = 32'h1C71_C71C;
      10: m = 32'h1999_9999;
      11: m = 32'h1745_D174;
      12: m = 32'h1555_5555;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/ebc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ebc_pkg (widths, side_t).
module ebc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [ebc_pkg::DIV_NW-1:0]  in_num,
  input  logic [ebc_pkg::DIV_DW-1:0]  in_den,
  input  ebc_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [ebc_pkg::QW-1:0]      out_quo,
  output ebc_pkg::side_t              out_side
);

  localparam int QW = ebc_pkg::QW;
  localparam int NW = ebc_pkg::DIV_NW;
  localparam int DW = ebc_pkg::DIV_DW;

  logic [DW-1:0] rem_r [QW];
  logic [NW-1:0] num_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic          vld_r [QW];
  ebc_pkg::side_t side_r [QW];

  logic [DW-1:0] rem_in [QW];
  logic [NW-1:0] num_in [QW];
  logic [DW-1:0] den_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic          vld_in [QW];
  ebc_pkg::side_t side_in [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0] trial;
    logic        fits;

    if (i == 0) begin : g_first
      assign rem_in[i] = DW'(in_num[NW-1:QW]);
      assign num_in[i] = in_num;
      assign den_in[i] = in_den;
      assign quo_in[i] = '0;
      assign vld_in[i] = in_valid;
      assign side_in[i] = in_side;
    end else begin : g_next
      assign rem_in[i] = rem_r[i-1];
      assign num_in[i] = num_r[i-1];
      assign den_in[i] = den_r[i-1];
      assign quo_in[i] = quo_r[i-1];
      assign vld_in[i] = vld_r[i-1];
      assign side_in[i] = side_r[i-1];
    end

    always_comb begin
      trial = {rem_in[i], num_in[i][QW-1-i]};
      fits = (trial >= {1'b0, den_in[i]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in[i];
      end
      rem_r[i] <= fits ? DW'(trial - {1'b0, den_in[i]}) : DW'(trial);
      num_r[i] <= num_in[i];
      den_r[i] <= den_in[i];
      quo_r[i] <= {quo_in[i][QW-2:0], fits};
      side_r[i] <= side_in[i];
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo = quo_r[QW-1];
  assign out_side = side_r[QW-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rem_r[QW-1] < den_r[QW-1]))
    else $error("divider remainder not below divisor");

endmodule

// ----- rtl/ebc_exp.sv -----
// Pipelined exp(-a*s) in Q.30 for two lanes: s from the item and s = 1.
// Depends on ebc_pkg (constants, reciprocal table, side_t).
module ebc_exp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [15:0]             in_mag,
  input  logic [ebc_pkg::XW-1:0]  in_s,
  input  ebc_pkg::side_t          in_side,
  output logic                    out_valid,
  output logic [30:0]             out_e1,
  output logic [30:0]             out_e0,
  output ebc_pkg::side_t          out_side
);

  localparam int HT = ebc_pkg::HTERMS;
  localparam int LAT = ebc_pkg::EXP_LAT;

  logic [ebc_pkg::XW-1:0] s_lane [2];
  logic [27:0] u_r [2];
  logic [4:0]  n1_r [2];
  logic [31:0] f_r [2];
  logic [4:0]  n2_r [2];
  logic [29:0] y_r [2];
  logic [30:0] e_r [2];

  // Horner pipeline: A multiplies, B takes the reciprocal, C corrects
  logic [29:0] ap_r [2][HT];
  logic [29:0] ay_r [2][HT];
  logic [4:0]  an_r [2][HT];
  logic [29:0] bq_r [2][HT];
  logic [29:0] bp_r [2][HT];
  logic [29:0] by_r [2][HT];
  logic [4:0]  bn_r [2][HT];
  logic [30:0] ct_r [2][HT];
  logic [29:0] cy_r [2][HT];
  logic [4:0]  cn_r [2][HT];

  logic           vld_sr [LAT];
  ebc_pkg::side_t side_sr [LAT];

  assign s_lane[0] = in_s;
  assign s_lane[1] = ebc_pkg::ONE_X;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [32:0] usum;
    logic [56:0] vprod;
    logic [63:0] yprod;

    always_comb begin
      usum = 33'(in_mag) * 33'(s_lane[g]) + 33'd8;
      vprod = 57'(u_r[g]) * 57'(ebc_pkg::LOG2E_Q28);
      yprod = 64'(f_r[g]) * 64'(ebc_pkg::LN2_Q32);
    end

    always_ff @(posedge clk) begin
      u_r[g] <= usum[31:4];
      n1_r[g] <= vprod[56:52];
      f_r[g] <= vprod[51:20];
      n2_r[g] <= n1_r[g];
      y_r[g] <= yprod[63:34];
    end

    for (genvar j = 0; j < HT; j++) begin : g_term
      localparam int K = HT - j;
      localparam logic [31:0] M = ebc_pkg::recip_q32(K);
      localparam logic [3:0] KV = 4'(K);
      logic [30:0] t_prev;
      logic [29:0] y_prev;
      logic [4:0]  n_prev;
      logic [60:0] aprod;
      logic [61:0] bprod;
      logic [29:0] qk;
      logic [29:0] rem;
      logic [29:0] quo;

      if (j == 0) begin : g_first
        assign t_prev = ebc_pkg::ONE_Q30;
        assign y_prev = y_r[g];
        assign n_prev = n2_r[g];
      end else begin : g_next
        assign t_prev = ct_r[g][j-1];
        assign y_prev = cy_r[g][j-1];
        assign n_prev = cn_r[g][j-1];
      end

      always_comb begin
        aprod = 61'(y_prev) * 61'(t_prev);
        bprod = 62'(ap_r[g][j]) * 62'(M);
        qk = 30'(bq_r[g][j] * 30'(KV));
        rem = bp_r[g][j] - qk;
        quo = bq_r[g][j] + 30'(rem >= 30'(KV));
      end

      always_ff @(posedge clk) begin
        ap_r[g][j] <= aprod[59:30];
        ay_r[g][j] <= y_prev;
        an_r[g][j] <= n_prev;
        bq_r[g][j] <= bprod[61:32];
        bp_r[g][j] <= ap_r[g][j];
        by_r[g][j] <= ay_r[g][j];
        bn_r[g][j] <= an_r[g][j];
        ct_r[g][j] <= ebc_pkg::ONE_Q30 - {1'b0, quo};
        cy_r[g][j] <= by_r[g][j];
        cn_r[g][j] <= bn_r[g][j];
      end
    end

    // scale by 2^-n with rounding
    logic [31:0] tsum;
    logic [4:0]  nsh;
    logic [30:0] scaled;

    always_comb begin
      nsh = cn_r[g][HT-1];
      tsum = {1'b0, ct_r[g][HT-1]} + (32'd1 << 5'(nsh - 5'd1));
      scaled = (nsh == 5'd0) ? ct_r[g][HT-1] : 31'(tsum >> nsh);
    end

    always_ff @(posedge clk) begin
      e_r[g] <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld_sr[i] <= 1'b0;
      end
    end else begin
      vld_sr[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld_sr[i] <= vld_sr[i-1];
      end
    end
    side_sr[0] <= in_side;
    for (int i = 1; i < LAT; i++) begin
      side_sr[i] <= side_sr[i-1];
    end
  end

  assign out_valid = vld_sr[LAT-1];
  assign out_side = side_sr[LAT-1];
  assign out_e1 = e_r[0];
  assign out_e0 = e_r[1];

  a_exp_at_most_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_e0 <= ebc_pkg::ONE_Q30 && out_e1 <= ebc_pkg::ONE_Q30))
    else $error("exp result above one");

endmodule

// ----- rtl/exponential_brightness_curve_top.sv -----
// Top level of the exponential brightness curve: registers, clamp, curve math.
// Depends on ebc_pkg, ebc_div and ebc_exp.
// drive and saturated are registered in the same cycle as done for each taken start.
// Throughput: one item per cycle; busy stays low, set by the fully pipelined
// dividers and exp lanes (input reg 1, divider 17, exp 40, prep 1, divider 17, out 1).
// Reset: synchronous rst clears all valid bits and done and loads the register
// defaults (full_scale 100, curve_min 1, curve_max 100, curve_power 0.5).
module exponential_brightness_curve_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [ebc_pkg::LW-1:0]  level,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  output logic                    done,
  output logic [7:0]              drive,
  output logic                    saturated
);

  localparam int XW = ebc_pkg::XW;
  localparam int FB = ebc_pkg::FB;

  // configuration registers
  logic [15:0] full_scale;
  logic [7:0]  curve_min;
  logic [7:0]  curve_max;
  logic [15:0] curve_power;

  // the pipeline never stalls, so both handshakes are always open
  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= 16'd100;
      curve_min <= 8'd1;
      curve_max <= 8'd100;
      curve_power <= 16'd2048;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ebc_pkg::REG_FULL_SCALE: full_scale <= cfg_data;
        ebc_pkg::REG_CURVE_MIN: curve_min <= cfg_data[7:0];
        ebc_pkg::REG_CURVE_MAX: curve_max <= cfg_data[7:0];
        ebc_pkg::REG_CURVE_POWER: curve_power <= cfg_data;
        default: ;
      endcase
    end
  end

  // Power decode; the user must change the registers only while the pipe is empty;
  // the block does not enforce this, and every stage reads them directly.
  logic        neg;
  logic [15:0] mag;
  logic        lin;

  always_comb begin
    neg = curve_power[15];
    mag = neg ? 16'(~curve_power + 16'd1) : curve_power;
    lin = (23'(mag) * 23'd100) < 23'(ebc_pkg::LIN_LIMIT);
  end

  // Input stage: clamp to full scale and build the rounded x dividend.
  logic [15:0] fs;
  logic        over;
  logic [ebc_pkg::LW-1:0] lvl_c;
  logic        s0_valid;
  logic [ebc_pkg::DIV_NW-1:0] s0_num;
  logic [ebc_pkg::DIV_DW-1:0] s0_den;
  ebc_pkg::side_t s0_side;

  always_comb begin
    fs = (full_scale == 16'd0) ? 16'd1 : full_scale;
    over = (level > fs);
    lvl_c = over ? fs : level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_num <= ebc_pkg::DIV_NW'({lvl_c, 16'd0}) + ebc_pkg::DIV_NW'(fs[15:1]);
    s0_den <= ebc_pkg::DIV_DW'(fs);
    s0_side <= '{sat: over, byp: 1'b0, x: '0};
  end

  // x = level / full_scale in Q1.16
  logic d1_valid;
  logic [XW-1:0] d1_quo;
  ebc_pkg::side_t d1_side;

  ebc_div u_div_x (
    .clk(clk), .rst(rst),
    .in_valid(s0_valid), .in_num(s0_num), .in_den(s0_den), .in_side(s0_side),
    .out_valid(d1_valid), .out_quo(d1_quo), .out_side(d1_side)
  );

  // exp(-a*s) for the item's s and for s = 1
  logic [XW-1:0] exp_s;
  ebc_pkg::side_t exp_in_side;
  logic ex_valid;
  logic [30:0] ex_e1;
  logic [30:0] ex_e0;
  ebc_pkg::side_t ex_side;

  always_comb begin
    exp_s = neg ? d1_quo : ebc_pkg::ONE_X - d1_quo;
    exp_in_side = '{sat: d1_side.sat, byp: 1'b0, x: d1_quo};
  end

  ebc_exp u_exp (
    .clk(clk), .rst(rst),
    .in_valid(d1_valid), .in_mag(mag), .in_s(exp_s), .in_side(exp_in_side),
    .out_valid(ex_valid), .out_e1(ex_e1), .out_e0(ex_e0), .out_side(ex_side)
  );

  // Prep stage: numerator and denominator of the curve quotient.
  logic [XW-1:0] xx;
  logic          degen;
  logic [30:0]   den;
  logic [30:0]   num_raw;
  logic [30:0]   num;
  logic          p_valid;
  logic [ebc_pkg::DIV_NW-1:0] p_num;
  logic [ebc_pkg::DIV_DW-1:0] p_den;
  ebc_pkg::side_t p_side;

  always_comb begin
    xx = neg ? ebc_pkg::ONE_X - ex_side.x : ex_side.x;
    degen = (ex_e0 >= ebc_pkg::ONE_Q30);
    num_raw = (ex_e1 > ex_e0) ? ex_e1 - ex_e0 : 31'd0;
    den = ebc_pkg::ONE_Q30 - ex_e0;
    num = (num_raw > den) ? den : num_raw;
    // keep the divider fed with a legal divisor when the curve is bypassed
    if (degen) begin
      den = 31'd1;
      num = 31'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= ex_valid;
    end
    p_num <= ebc_pkg::DIV_NW'({num, 16'd0}) + ebc_pkg::DIV_NW'(den[30:1]);
    p_den <= ebc_pkg::DIV_DW'(den);
    p_side <= '{sat: ex_side.sat, byp: lin || degen, x: xx};
  end

  logic d2_valid;
  logic [XW-1:0] d2_quo;
  ebc_pkg::side_t d2_side;

  ebc_div u_div_curve (
    .clk(clk), .rst(rst),
    .in_valid(p_valid), .in_num(p_num), .in_den(p_den), .in_side(p_side),
    .out_valid(d2_valid), .out_quo(d2_quo), .out_side(d2_side)
  );

  // Output stage: mirror for falling power, then scale into [min, max].
  logic [XW-1:0] cpos;
  logic [XW-1:0] cval;
  logic signed [27:0] span;
  logic signed [27:0] total;

  always_comb begin
    cpos = d2_side.byp ? d2_side.x : d2_quo;
    cval = neg ? ebc_pkg::ONE_X - cpos : cpos;
    span = signed'(28'(curve_max)) - signed'(28'(curve_min));
    total = signed'(28'(curve_min) << FB) + span * signed'(28'(cval))
          + signed'(28'(32768));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_valid;
    end
    drive <= total[27] ? 8'd0 : total[23:16];
    saturated <= d2_side.sat;
  end

  a_drive_in_limits: assert property (@(posedge clk) disable iff (rst)
    done |-> ((drive >= curve_min && drive <= curve_max)
           || (drive <= curve_min && drive >= curve_max)))
    else $error("drive outside curve limits");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for exponential_brightness_curve_top.
// Depends on ebc_pkg and the RTL top level. Predicts drive and saturated in
// fixed point, checks each done strobe in order, and reconfigures between phases.
module testbench;

  typedef enum logic [1:0] {OP_LEVEL, OP_WRITE, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t    kind;
    logic [15:0] level;
    logic [1:0]  index;
    logic [15:0] data;
  } op_t;

  typedef struct {
    logic [7:0] drive;
    logic       saturated;
  } drive_t;

  // settle time after the last result before a register write
  localparam int SETTLE_CYCLES = 90;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] level = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic [7:0]  drive;
  logic        saturated;

  exponential_brightness_curve_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .level(level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .drive(drive), .saturated(saturated)
  );

  always #1 clk = ~clk;

  // predictor copy of the registers
  logic [15:0] mdl_full_scale = 16'd100;
  logic [7:0]  mdl_min = 8'd1;
  logic [7:0]  mdl_max = 8'd100;
  logic [15:0] mdl_power = 16'd2048;

  op_t    pending_ops[$];
  drive_t expected_drives[$];
  int     errors = 0;
  int     quiet_cycles = 0;
  bit     level_taken = 0;
  bit     write_taken = 0;
  int     burst_left = 0;
  int     gap_left = 0;

  // exp(-a*s) in Q.30; a in Q.12, s in Q.16
  function automatic bit [63:0] decay_q30(bit [63:0] a, bit [63:0] s);
    bit [63:0] u, v, n, f, y, t;
    u = a * s;
    u = (u + 64'd8) >> 4;
    v = u * 64'h1715_4765;
    n = v >> 52;
    f = (v >> 20) & 64'hFFFF_FFFF;
    y = (f * 64'hB172_17F8) >> 34;
    t = 64'd1 << 30;
    for (int k = 12; k >= 1; k--)
      t = (64'd1 << 30) - ((y * t) >> 30) / 64'(k);
    if (n > 31) return 64'd0;
    if (n == 0) return t;
    return (t + (64'd1 << (n - 1))) >> n;
  endfunction

  // rising curve for magnitude a at fraction x, Q1.16
  function automatic bit [63:0] rising_curve(bit [63:0] a, bit [63:0] x);
    bit [63:0] e1, e0, den, num;
    e1 = decay_q30(a, 64'd65536 - x);
    e0 = decay_q30(a, 64'd65536);
    if (e0 >= (64'd1 << 30)) return x;
    den = (64'd1 << 30) - e0;
    num = (e1 > e0) ? e1 - e0 : 64'd0;
    if (num > den) num = den;
    return ((num << 16) + den / 2) / den;
  endfunction

  function automatic drive_t predict_drive(logic [15:0] lvl_in);
    drive_t      r;
    bit [63:0]   lvl, fs, x, c, mag;
    longint      pw, total;
    lvl = 64'(lvl_in);
    fs = (mdl_full_scale == 16'd0) ? 64'd1 : 64'(mdl_full_scale);
    r.saturated = 1'b0;
    if (lvl > fs) begin
      lvl = fs;
      r.saturated = 1'b1;
    end
    x = ((lvl << 16) + fs / 2) / fs;
    pw = longint'($signed(mdl_power));
    mag = (pw < 0) ? 64'(-pw) : 64'(pw);
    if (mag * 100 < 64'd4096) c = x;
    else if (pw > 0) c = rising_curve(mag, x);
    else c = 64'd65536 - rising_curve(mag, 64'd65536 - x);
    total = longint'({mdl_min, 16'd0}) + (longint'(mdl_max) - longint'(mdl_min))
          * longint'(c) + 32768;
    if (total < 0) total = 0;
    r.drive = 8'(total >>> 16);
    return r;
  endfunction

  // Monitor: record what was taken at this edge, predict, and check results.
  always @(posedge clk) begin
    drive_t want;
    bit     lvl_hit;
    bit     cfg_hit;
    lvl_hit = !rst && start && !busy;
    cfg_hit = !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (done) begin
        if (expected_drives.size() == 0) begin
          $error("unexpected result drive=%0d saturated=%0d", drive, saturated);
          errors++;
        end else begin
          want = expected_drives.pop_front();
          if (drive !== want.drive) begin
            $error("drive: expected %0d actual %0d", want.drive, drive);
            errors++;
          end
          if (saturated !== want.saturated) begin
            $error("saturated: expected %0d actual %0d", want.saturated, saturated);
            errors++;
          end
        end
      end
      if (lvl_hit) begin
        expected_drives.push_back(predict_drive(level));
      end
      if (cfg_hit) begin
        case (cfg_index)
          ebc_pkg::REG_FULL_SCALE:  mdl_full_scale = cfg_data;
          ebc_pkg::REG_CURVE_MIN:   mdl_min = cfg_data[7:0];
          ebc_pkg::REG_CURVE_MAX:   mdl_max = cfg_data[7:0];
          ebc_pkg::REG_CURVE_POWER: mdl_power = cfg_data;
          default: ;
        endcase
      end
      // count cycles with nothing outstanding
      if (expected_drives.size() == 0 && !start && !done) quiet_cycles++;
      else quiet_cycles = 0;
    end
    level_taken <= lvl_hit;
    write_taken <= cfg_hit;
  end

  // Driver: change inputs at the falling edge, one assignment per signal.
  always @(negedge clk) begin
    logic        nxt_start, nxt_valid;
    logic [15:0] nxt_level, nxt_data;
    logic [1:0]  nxt_index;
    bit          holding;
    nxt_start = start;
    nxt_valid = cfg_valid;
    nxt_level = level;
    nxt_data = cfg_data;
    nxt_index = cfg_index;
    holding = (start && !level_taken) || (cfg_valid && !write_taken);
    if (!rst && !holding) begin
      nxt_start = 1'b0;
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        case (pending_ops[0].kind)
          OP_LEVEL: begin
            nxt_start = 1'b1;
            nxt_level = pending_ops[0].level;
            void'(pending_ops.pop_front());
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 40);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
          OP_WRITE: begin
            // write only once the pipe has fully drained
            if (quiet_cycles >= SETTLE_CYCLES) begin
              nxt_valid = 1'b1;
              nxt_index = pending_ops[0].index;
              nxt_data = pending_ops[0].data;
              void'(pending_ops.pop_front());
            end
          end
          default: begin
            if (expected_drives.size() == 0) void'(pending_ops.pop_front());
          end
        endcase
      end
    end
    start <= nxt_start;
    cfg_valid <= nxt_valid;
    level <= nxt_level;
    cfg_data <= nxt_data;
    cfg_index <= nxt_index;
  end

  task automatic add_level(logic [15:0] v);
    op_t o;
    o.kind = OP_LEVEL;
    o.level = v;
    o.index = '0;
    o.data = '0;
    pending_ops.push_back(o);
  endtask

  task automatic add_write(logic [1:0] idx, logic [15:0] v);
    op_t o;
    o.kind = OP_WRITE;
    o.level = '0;
    o.index = idx;
    o.data = v;
    pending_ops.push_back(o);
  endtask

  task automatic add_setting(logic [15:0] fs, logic [7:0] lo, logic [7:0] hi,
                             logic [15:0] pw);
    add_write(ebc_pkg::REG_FULL_SCALE, fs);
    add_write(ebc_pkg::REG_CURVE_MIN, 16'(lo));
    add_write(ebc_pkg::REG_CURVE_MAX, 16'(hi));
    add_write(ebc_pkg::REG_CURVE_POWER, pw);
  endtask

  // Fill the stimulus: directed corners first, then random phases.
  initial begin
    logic [15:0] fs, pw;
    int pick;
    // default registers: extremes of the level and clamping
    add_level(16'd0);
    add_level(16'd50);
    add_level(16'd100);
    add_level(16'd101);
    add_level(16'hFFFF);
    // zero full scale acts as one; reversed limits; most negative power
    add_setting(16'd0, 8'd255, 8'd0, 16'h8000);
    add_level(16'd0);
    add_level(16'd1);
    add_level(16'd2);
    // small power selects the linear curve, just below and just above the limit
    add_setting(16'd65535, 8'd0, 8'd255, 16'd40);
    add_level(16'd0);
    add_level(16'd32768);
    add_level(16'hFFFF);
    add_setting(16'd1000, 8'd0, 8'd255, 16'd41);
    add_level(16'd500);
    add_level(16'd999);
    add_setting(16'd1000, 8'd10, 8'd200, 16'hFFD7);
    add_level(16'd250);
    // largest positive power: denominator close to one
    add_setting(16'd255, 8'd0, 8'd255, 16'h7FFF);
    add_level(16'd128);
    add_level(16'd254);
    add_level(16'd255);
    // zero power, equal limits
    add_setting(16'd1, 8'd77, 8'd77, 16'd0);
    add_level(16'd1);
    add_level(16'd3);
    // hold off until every result has come back
    begin
      op_t d;
      d.kind = OP_DRAIN;
      d.level = '0;
      d.index = '0;
      d.data = '0;
      pending_ops.push_back(d);
    end
    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      pick = $urandom_range(0, 3);
      fs = (pick == 0) ? 16'($urandom_range(0, 16)) :
           (pick == 1) ? 16'hFFFF : 16'($urandom());
      pick = $urandom_range(0, 5);
      pw = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF :
           (pick == 2) ? 16'($signed($urandom_range(0, 80)) - 40) : 16'($urandom());
      add_setting(fs, 8'($urandom()), 8'($urandom()), pw);
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 1) == 0) add_level(16'($urandom()));
        else add_level(16'($urandom_range(0, int'(fs) + 2)));
      end
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // wait for the queue to drain and the pipe to empty
    @(posedge clk);
    while (pending_ops.size() > 0 || start || expected_drives.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_drives.size() == 0)
      $display("exponential_brightness_curve_top regression: pass");
    else
      $display("exponential_brightness_curve_top regression: fail");
    $finish;
  end

  // hard limit on the run
  initial begin
    #2000000;
    $display("exponential_brightness_curve_top regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ebc_pkg.sv
rtl/ebc_div.sv
rtl/ebc_exp.sv
rtl/exponential_brightness_curve_top.sv
verif/testbench.sv
